// ----- design/mps_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mps_pkg
// Shared types and constants for the modular power-of-sixteen block.
// ----------------------------------------------------------------------------
package mps_pkg;

   // Datapath operations issued by the controller
   typedef enum logic [3:0] {
      OP_IDLE,
      OP_LOAD,      // capture operands, residue = 1
      OP_ZERO,      // residue = 0
      OP_SHIFT,     // shift exponent left by one
      OP_MSTART,    // acc = 0, multiplier = residue
      OP_MDBL,      // acc = 2*acc mod m
      OP_MADD,      // acc += residue mod m if multiplier msb, shift multiplier
      OP_COMMIT,    // residue = acc
      OP_X2,        // residue = 2*residue mod m
      OP_PUBLISH    // output register = residue
   } op_type;

   typedef struct packed {
      logic exp_msb;    // current top bit of the exponent
      logic exp_zero;   // exponent is zero
      logic mod_small;  // modulus is zero or one
   } status_type;

   // doublings that make up one multiply by sixteen
   localparam int unsigned X16_STEPS = 4;

endpackage

// ----- design/mps_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mps_req_if / mps_rsp_if
// Valid/ready channels carrying operands in and residues out.
// ----------------------------------------------------------------------------
interface mps_req_if #(
   parameter int unsigned EXP_BITS = 25,
   parameter int unsigned MOD_BITS = 26
);
   logic                valid;
   logic                ready;
   logic [EXP_BITS-1:0] exponent;
   logic [MOD_BITS-1:0] modulus;

   modport source (output valid, output exponent, output modulus, input ready);
   modport sink   (input valid, input exponent, input modulus, output ready);
endinterface

interface mps_rsp_if #(
   parameter int unsigned MOD_BITS = 26
);
   logic                valid;
   logic                ready;
   logic [MOD_BITS-1:0] residue;

   modport source (output valid, output residue, input ready);
   modport sink   (input valid, input residue, output ready);
endinterface

// ----- design/mps_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mps_datapath
// Operand registers, running residue and a shared bit-serial modular
// multiplier built around one add-and-reduce unit.
// ----------------------------------------------------------------------------
module mps_datapath #(
   parameter int unsigned EXP_BITS = 25,
   parameter int unsigned MOD_BITS = 26
) (
   input  logic                clock,
   input  mps_pkg::op_type     op,
   input  logic [EXP_BITS-1:0] exponent,
   input  logic [MOD_BITS-1:0] modulus,
   output mps_pkg::status_type status,
   output logic [MOD_BITS-1:0] residue
);
   import mps_pkg::*;

   logic [EXP_BITS-1:0] exp_ff, exp_in;
   logic [MOD_BITS-1:0] mod_ff, mod_in;
   logic [MOD_BITS-1:0] res_ff, res_in;
   logic [MOD_BITS-1:0] acc_ff, acc_in;
   logic [MOD_BITS-1:0] mb_ff, mb_in;
   logic [MOD_BITS-1:0] out_ff, out_in;

   logic [MOD_BITS-1:0] opa, opb, reduced;
   logic [MOD_BITS:0]   sum;
   logic [MOD_BITS+1:0] diff;

   // a + b with both below m, reduced by one conditional subtract
   always_comb begin
      opa = acc_ff;
      opb = acc_ff;
      unique case (op)
         OP_MADD: opb = res_ff;
         OP_X2: begin
            opa = res_ff;
            opb = res_ff;
         end
         default: ;
      endcase
      sum     = {1'b0, opa} + {1'b0, opb};
      diff    = {1'b0, sum} - {2'b00, mod_ff};
      reduced = diff[MOD_BITS+1] ? sum[MOD_BITS-1:0] : diff[MOD_BITS-1:0];
   end

   always_comb begin
      exp_in = exp_ff;
      mod_in = mod_ff;
      res_in = res_ff;
      acc_in = acc_ff;
      mb_in  = mb_ff;
      out_in = out_ff;
      unique case (op)
         OP_LOAD: begin
            exp_in = exponent;
            mod_in = modulus;
            res_in = MOD_BITS'(1);
         end
         OP_ZERO:   res_in = '0;
         OP_SHIFT:  exp_in = {exp_ff[EXP_BITS-2:0], 1'b0};
         OP_MSTART: begin
            acc_in = '0;
            mb_in  = res_ff;
         end
         OP_MDBL:   acc_in = reduced;
         OP_MADD: begin
            if (mb_ff[MOD_BITS-1]) begin
               acc_in = reduced;
            end
            mb_in = {mb_ff[MOD_BITS-2:0], 1'b0};
         end
         OP_COMMIT:  res_in = acc_ff;
         OP_X2:      res_in = reduced;
         OP_PUBLISH: out_in = res_ff;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      exp_ff <= exp_in;
      mod_ff <= mod_in;
      res_ff <= res_in;
      acc_ff <= acc_in;
      mb_ff  <= mb_in;
      out_ff <= out_in;
   end

   assign status.exp_msb   = exp_ff[EXP_BITS-1];
   assign status.exp_zero  = (exp_ff == '0);
   assign status.mod_small = (mod_ff[MOD_BITS-1:1] == '0);
   assign residue          = out_ff;

endmodule

// ----- design/mps_controller.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mps_controller
// Sequencer: scans exponent bits from the top, squares and multiplies by
// sixteen through datapath commands, and owns both handshakes.
// ----------------------------------------------------------------------------
module mps_controller #(
   parameter int unsigned EXP_BITS = 25,
   parameter int unsigned MOD_BITS = 26
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   input  mps_pkg::status_type status,
   output mps_pkg::op_type     op
);
   import mps_pkg::*;

   localparam int unsigned CNT_W  = $clog2(EXP_BITS + 1);
   localparam int unsigned MCNT_W = $clog2(MOD_BITS + 1);
   localparam int unsigned XCNT_W = $clog2(X16_STEPS);

   typedef enum logic [3:0] {
      S_IDLE, S_CHECK, S_SEEK, S_MSTART, S_MDBL, S_MADD,
      S_NEXT, S_X16, S_STEP, S_FINISH
   } state_type;

   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [MCNT_W-1:0]  mcnt_ff, mcnt_in;
   logic [XCNT_W-1:0]  xcnt_ff, xcnt_in;
   logic               rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      mcnt_in   = mcnt_ff;
      xcnt_in   = xcnt_ff;
      op        = OP_IDLE;
      req_ready = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               op       = OP_LOAD;
               cnt_in   = CNT_W'(EXP_BITS);
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            priority if (status.mod_small) begin
               op       = OP_ZERO;
               state_in = S_FINISH;
            end else if (status.exp_zero) begin
               state_in = S_FINISH;
            end else begin
               state_in = S_SEEK;
            end
         end
         S_SEEK: begin
            if (status.exp_msb) begin
               state_in = S_MSTART;
            end else begin
               op     = OP_SHIFT;
               cnt_in = cnt_ff - CNT_W'(1);
            end
         end
         S_MSTART: begin
            op       = OP_MSTART;
            mcnt_in  = MCNT_W'(MOD_BITS);
            state_in = S_MDBL;
         end
         S_MDBL: begin
            op       = OP_MDBL;
            state_in = S_MADD;
         end
         S_MADD: begin
            op       = OP_MADD;
            mcnt_in  = mcnt_ff - MCNT_W'(1);
            state_in = (mcnt_ff == MCNT_W'(1)) ? S_NEXT : S_MDBL;
         end
         S_NEXT: begin
            op      = OP_COMMIT;
            xcnt_in = '0;
            state_in = status.exp_msb ? S_X16 : S_STEP;
         end
         S_X16: begin
            op      = OP_X2;
            xcnt_in = xcnt_ff + XCNT_W'(1);
            if (xcnt_ff == XCNT_W'(X16_STEPS - 1)) begin
               state_in = S_STEP;
            end
         end
         S_STEP: begin
            op       = OP_SHIFT;
            cnt_in   = cnt_ff - CNT_W'(1);
            state_in = (cnt_ff == CNT_W'(1)) ? S_FINISH : S_MSTART;
         end
         S_FINISH: begin
            // output register free or draining this cycle
            if (!rsp_valid_ff || rsp_ready) begin
               op           = OP_PUBLISH;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         mcnt_ff      <= '0;
         xcnt_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         mcnt_ff      <= mcnt_in;
         xcnt_ff      <= xcnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ----- design/modular_power_of_sixteen.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modular_power_of_sixteen
// Returns 16^exponent mod modulus by left-to-right binary exponentiation.
// ----------------------------------------------------------------------------
// Usage:
//   req_bus carries one beat of {exponent, modulus}; rsp_bus returns one beat
//   holding the residue. A beat moves when valid and ready are both high.
//   A modulus of zero or one gives zero; an exponent of zero gives one.
// Sequencing:
//   One item at a time. Each exponent bit from the top set bit down takes
//   a square in the bit-serial modular multiplier, which shares one
//   add-and-reduce unit, plus a multiply by sixteen through repeated
//   doubling when the bit is one; leading zeros are skipped by shifting.
// Output:
//   The residue sits in an output register; req_bus is ready again as soon
//   as it is loaded; a stalled receiver holds back the next result and input.
//   Reset returns the sequencer to idle and empties the output register.
// ----------------------------------------------------------------------------
module modular_power_of_sixteen #(
   parameter int unsigned EXP_BITS = 25,
   parameter int unsigned MOD_BITS = 26
) (
   input  logic     clock,
   input  logic     reset,
   mps_req_if.sink  req_bus,
   mps_rsp_if.source rsp_bus
);
   import mps_pkg::*;

   op_type     op;
   status_type status;

   mps_controller #(
      .EXP_BITS(EXP_BITS),
      .MOD_BITS(MOD_BITS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .status    (status),
      .op        (op)
   );

   mps_datapath #(
      .EXP_BITS(EXP_BITS),
      .MOD_BITS(MOD_BITS)
   ) u_dp (
      .clock    (clock),
      .op       (op),
      .exponent (req_bus.exponent),
      .modulus  (req_bus.modulus),
      .status   (status),
      .residue  (rsp_bus.residue)
   );

endmodule

// ----- bench/tb_modular_power_of_sixteen.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_modular_power_of_sixteen
// Self-checking bench for the 16^exponent mod modulus block.
// ----------------------------------------------------------------------------
// Operand beats come from a queue that the stimulus block fills. A driver at
// the falling edge offers them with random gaps. A bit-exact exponentiation
// predictor fills a queue of due residues when each beat is taken. The
// monitor compares every residue beat with the oldest due value. The run
// covers a directed set of corner operands, then random operands in phases.
// The phases vary sender gaps and receiver stalls, and one phase holds the
// receiver off long enough that the block backs up its input.
// ----------------------------------------------------------------------------
module tb_modular_power_of_sixteen;

   localparam int unsigned EXP_W          = 25;
   localparam int unsigned MOD_W          = 26;
   localparam logic [EXP_W-1:0] EXP_MAX   = '1;
   localparam logic [MOD_W-1:0] MOD_MAX   = '1;
   localparam int unsigned STALL_LIMIT    = 24000;
   localparam int unsigned HOLDOFF_CYCLES = 3000;
   localparam int unsigned TAIL_CYCLES    = 1600;

   typedef struct packed {
      logic [EXP_W-1:0] exponent;
      logic [MOD_W-1:0] modulus;
   } operand_beat_type;

   logic clock;
   logic reset;

   mps_req_if #(.EXP_BITS(EXP_W), .MOD_BITS(MOD_W)) req_bus ();
   mps_rsp_if #(.MOD_BITS(MOD_W)) rsp_bus ();

   modular_power_of_sixteen #(
      .EXP_BITS(EXP_W),
      .MOD_BITS(MOD_W)
   ) dut (
      .clock  (clock),
      .reset  (reset),
      .req_bus(req_bus),
      .rsp_bus(rsp_bus)
   );

   operand_beat_type operands_pending[$];
   logic [MOD_W-1:0] residues_due[$];
   logic [MOD_W-1:0] model_residue;

   int unsigned queued_count;
   int unsigned taken_count;
   int unsigned checked_count;
   int unsigned mismatch_count;
   int unsigned zero_exp_count;
   int unsigned small_mod_count;
   int unsigned idle_cycles;

   logic req_beat_done;
   logic rsp_beat_done;
   logic req_idle_on;
   logic rsp_idle_on;
   logic holdoff_req;
   logic holdoff_started;
   int unsigned req_gap_left;
   int unsigned rsp_stall_left;
   int unsigned holdoff_left;

   // left-to-right square and multiply, exact integers
   function automatic logic [MOD_W-1:0] pow16_residue(input logic [EXP_W-1:0] e,
                                                      input logic [MOD_W-1:0] m);
      longint unsigned acc;
      int top;
      acc = 1;
      top = -1;
      if (m <= 1)
         return '0;
      for (int b = 0; b < EXP_W; b++)
         if (e[b])
            top = b;
      for (int b = top; b >= 0; b--) begin
         acc = (acc * acc) % m;
         if (e[b])
            acc = (acc * 16) % m;
      end
      return acc[MOD_W-1:0];
   endfunction

   task automatic report_mismatch(input string what, input logic [MOD_W-1:0] want,
                                  input logic [MOD_W-1:0] got);
      mismatch_count++;
      $display("[%0t] ERROR %s: expected %0d, got %0d", $realtime, what, want, got);
   endtask

   task automatic queue_operands(input logic [EXP_W-1:0] e, input logic [MOD_W-1:0] m);
      operand_beat_type beat;
      beat.exponent = e;
      beat.modulus  = m;
      operands_pending.push_back(beat);
      queued_count++;
   endtask

   // most exponents are short to keep the run time down; a fifth use all bits
   task automatic queue_random(input int unsigned count, input int unsigned exp_w_max);
      logic [31:0] e;
      logic [31:0] m;
      int unsigned w;
      for (int unsigned i = 0; i < count; i++) begin
         if ($urandom_range(0, 4) == 0) begin
            e = $urandom;
         end else begin
            w = $urandom_range(0, exp_w_max);
            e = $urandom & ((32'd1 << w) - 1);
         end
         case ($urandom_range(0, 5))
            0: m = $urandom_range(0, 20);
            1: m = 32'd1 << $urandom_range(0, MOD_W - 1);
            2: m = MOD_MAX - $urandom_range(0, 15);
            default: begin
               w = $urandom_range(2, MOD_W);
               m = ($urandom & ((32'd1 << w) - 1)) | (32'd1 << (w - 1));
            end
         endcase
         queue_operands(e[EXP_W-1:0], m[MOD_W-1:0]);
      end
   endtask

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // operand driver
   always @(negedge clock) begin
      if (reset) begin
         req_bus.valid    <= 1'b0;
         req_bus.exponent <= '0;
         req_bus.modulus  <= '0;
         req_gap_left = 0;
      end else if (!req_bus.valid || req_beat_done) begin
         if (req_beat_done)
            req_gap_left = req_idle_on ? $urandom_range(0, 6) : 0;
         if (req_gap_left > 0) begin
            req_gap_left--;
            req_bus.valid <= 1'b0;
         end else if (operands_pending.size() > 0) begin
            req_bus.exponent <= operands_pending[0].exponent;
            req_bus.modulus  <= operands_pending[0].modulus;
            req_bus.valid    <= 1'b1;
            void'(operands_pending.pop_front());
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // residue receiver: per-beat stalls plus one long hold-off
   always @(negedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         rsp_stall_left = 0;
         holdoff_left = 0;
      end else if (holdoff_req && !holdoff_started) begin
         holdoff_started = 1'b1;
         holdoff_left = HOLDOFF_CYCLES;
         rsp_bus.ready <= 1'b0;
      end else if (holdoff_left > 0) begin
         holdoff_left--;
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_beat_done)
            rsp_stall_left = rsp_idle_on ? $urandom_range(0, 6) : 0;
         if (rsp_stall_left > 0) begin
            rsp_stall_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // predictor on taken operands, checker on residue beats, watchdog
   always @(posedge clock) begin
      req_beat_done = 1'b0;
      rsp_beat_done = 1'b0;
      if (!reset) begin
         if (req_bus.valid && req_bus.ready) begin
            req_beat_done = 1'b1;
            model_residue = pow16_residue(req_bus.exponent, req_bus.modulus);
            residues_due.push_back(model_residue);
            taken_count++;
            if (req_bus.exponent == 0)
               zero_exp_count++;
            if (req_bus.modulus <= 1)
               small_mod_count++;
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            rsp_beat_done = 1'b1;
            if (residues_due.size() == 0) begin
               report_mismatch("residue beat with none due", '0, rsp_bus.residue);
            end else begin
               if (rsp_bus.residue !== residues_due[0])
                  report_mismatch("residue", residues_due[0], rsp_bus.residue);
               void'(residues_due.pop_front());
               checked_count++;
            end
         end
         if (req_beat_done || rsp_beat_done)
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("[%0t] ERROR no beat moved for %0d cycles", $realtime, idle_cycles);
            $display("modular_power_of_sixteen: mismatch");
            $finish;
         end
      end
   end

   initial begin
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.exponent = '0;
      req_bus.modulus = '0;
      rsp_bus.ready = 1'b0;
      req_beat_done = 1'b0;
      rsp_beat_done = 1'b0;
      req_idle_on = 1'b1;
      rsp_idle_on = 1'b1;
      holdoff_req = 1'b0;
      holdoff_started = 1'b0;
      model_residue = '0;
      queued_count = 0;
      taken_count = 0;
      checked_count = 0;
      mismatch_count = 0;
      zero_exp_count = 0;
      small_mod_count = 0;
      idle_cycles = 0;
      repeat (12) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      // corners: zero exponent, modulus of zero or one, extremes, powers of two
      queue_operands(25'd0, 26'd1);
      queue_operands(25'd0, 26'd2);
      queue_operands(25'd0, MOD_MAX);
      queue_operands(25'd0, 26'd0);
      queue_operands(EXP_MAX, MOD_MAX);
      queue_operands(EXP_MAX, 26'd1);
      queue_operands(EXP_MAX, 26'd0);
      queue_operands(EXP_MAX, 26'd2);
      queue_operands(EXP_MAX, 26'd3);
      queue_operands(25'd1, 26'd15);
      queue_operands(25'd1, 26'd16);
      queue_operands(25'd1, 26'd17);
      queue_operands(25'd1, MOD_MAX);
      queue_operands(25'd2, MOD_MAX);
      queue_operands(25'h1000000, MOD_MAX);
      queue_operands(25'h1000000, MOD_MAX - 26'd1);
      queue_operands(25'd12345, 26'h0010000);
      queue_operands(EXP_MAX, 26'h2000000);
      queue_operands(25'h1555555, 26'h2AAAAAA);
      queue_operands(25'h0AAAAAA, 26'h1555555);
      queue_operands(25'd5, 26'd7);
      queue_operands(25'd0, 26'd1);
      wait (taken_count == queued_count && residues_due.size() == 0);
      @(posedge clock);

      queue_random(150, 12);
      wait (taken_count == queued_count && residues_due.size() == 0);
      @(posedge clock);

      // receiver holds off while the sender keeps offering mostly short exponents
      req_idle_on = 1'b0;
      holdoff_req = 1'b1;
      queue_random(20, 6);
      wait (taken_count == queued_count && residues_due.size() == 0);
      @(posedge clock);

      rsp_idle_on = 1'b0;
      queue_random(140, 12);
      wait (taken_count == queued_count && residues_due.size() == 0);
      req_idle_on = 1'b1;
      rsp_idle_on = 1'b1;
      queue_random(150, 14);

      wait (taken_count == queued_count && residues_due.size() == 0);
      repeat (TAIL_CYCLES) @(posedge clock);
      $display("Checked %0d residues from %0d operand beats", checked_count, taken_count);
      $display("Operands with exponent zero: %0d, with modulus below two: %0d",
               zero_exp_count, small_mod_count);
      if (mismatch_count == 0 && residues_due.size() == 0) begin
         $display("modular_power_of_sixteen: match");
      end else begin
         $display("modular_power_of_sixteen: mismatch");
      end
      $finish;
   end

endmodule
